// File: hdl/prba_pkg.sv
// Shared constants and types of the page run bitmap allocator.
`default_nettype none

package prba_pkg;

   localparam int MAX_PAGES_DEF = 4096;
   localparam int PAGE_BYTES    = 4096;
   localparam int PAGE_SHIFT    = $clog2(PAGE_BYTES);
   localparam int WORD_BITS     = 32;
   localparam int WORD_SHIFT    = 5;
   localparam int ADDR_W        = 32;
   localparam int CNT_W         = 13;

   localparam logic [ADDR_W-1:0] KERNEL_BASE_RST  = 32'hC010_0000;
   localparam logic [CNT_W-1:0]  KERNEL_PAGES_RST = 13'd3840;
   localparam logic [ADDR_W-1:0] USER_BASE_RST    = 32'h0000_0000;
   localparam logic [CNT_W-1:0]  USER_PAGES_RST   = 13'd3840;

   typedef enum logic [1:0] {
      MODE_ALLOC = 2'd0,
      MODE_FREE  = 2'd1,
      MODE_CLAIM = 2'd2,
      MODE_RSVD  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      REG_KERNEL_BASE  = 2'd0,
      REG_KERNEL_PAGES = 2'd1,
      REG_USER_BASE    = 2'd2,
      REG_USER_PAGES   = 2'd3
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOCATE,
      ST_RANGE,
      ST_SCAN_RD,
      ST_SCAN_BITS,
      ST_MARK_RD,
      ST_MARK_WR,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

// File: hdl/prba_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none

module prba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// File: hdl/page_run_bitmap_allocator_unit.sv
// Free and claim pass LOCATE and RANGE, then read and rewrite each bitmap word touched
// (MARK_RD, MARK_WR) before DONE; allocate reads each word scanned (SCAN_RD), runs its
// 8-page slices through the run counter (SCAN_BITS) and marks the run found. Single-port
// bitmap RAM. One item at a time; a finished result waits in the output register while
// the next item is accepted. After reset the bitmap is cleared one word a cycle (all
// 2*MAX_PAGES/32 words, 256 by default) before the first item is accepted.
`default_nettype none

module page_run_bitmap_allocator_unit
   import prba_pkg::*;
#(
   parameter int MAX_PAGES = MAX_PAGES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   // configuration writes
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [ADDR_W-1:0] csr_wdata,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_mode,
   input  logic              req_pool,
   input  logic [CNT_W-1:0]  req_page_count,
   input  logic [ADDR_W-1:0] req_address,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [ADDR_W-1:0] rsp_page_address,
   output logic              rsp_ok
);

   localparam int WORDS = (2 * MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
   localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int GW    = AW + WORD_SHIFT;            // global bit index
   localparam int PCW   = $clog2(MAX_PAGES + 1);      // pool page count
   localparam int NW    = (PCW > CNT_W) ? PCW : CNT_W;
   localparam int PGW   = ADDR_W - PAGE_SHIFT;        // page index from address
   localparam int LW    = ((PGW > NW) ? PGW : NW) + 1;
   localparam logic [GW-1:0] POOL1_BIT = GW'(MAX_PAGES);

   // configuration registers
   logic [ADDR_W-1:0] kbase_ff, ubase_ff;
   logic [CNT_W-1:0]  kpages_ff, upages_ff;

   // sequencer and item registers
   state_type         state_ff, state_in;
   mode_type          mode_ff, mode_in;
   logic              pool_ff, pool_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [PCW-1:0]    npg_ff, npg_in;
   logic [PGW-1:0]    page_ff, page_in;
   logic              below_ff, below_in;
   logic [AW-1:0]     word_ff, word_in;
   logic [GW-1:0]     lo_bit_ff, lo_bit_in;
   logic [GW-1:0]     hi_bit_ff, hi_bit_in;
   logic [NW-1:0]     run_ff, run_in;
   logic [1:0]        slice_ff, slice_in;
   logic              set_ff, set_in;
   logic              ok_ff, ok_in;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] rsp_page_address_ff, rsp_page_address_in;
   logic              rsp_ok_ff, rsp_ok_in;

   // bitmap RAM
   logic                 ram_we;
   logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

   // shared combinational terms
   logic                 req_xfer, rsp_load;
   logic [CNT_W-1:0]     pages_sel;
   logic [GW-1:0]        pool_bit;
   logic [AW-1:0]        lo_word, hi_word;
   logic [4:0]           lo_pos, hi_pos;
   logic [WORD_BITS-1:0] word_mask;
   logic                 go_scan, go_mark;
   logic                 cnt_nz, cnt_fit, free_fit, claim_fit;
   logic [7:0]           slice_used;
   logic [NW-1:0]        run_v;
   logic                 scan_hit;
   logic [2:0]           hit_k;
   logic [GW-1:0]        hit_bit, hit_start;
   logic [GW-1:0]        start_page;

   prba_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (WORDS)
   ) u_bitmap (
      .clock (clock),
      .we    (ram_we),
      .addr  (word_ff),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign req_xfer  = req_valid && !req_stall;
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign pages_sel = req_pool ? upages_ff : kpages_ff;
   assign pool_bit  = pool_ff ? POOL1_BIT : '0;

   // Bits of the current word that lie in [lo_bit, hi_bit]; others count as used.
   assign lo_word   = lo_bit_ff[GW-1:WORD_SHIFT];
   assign hi_word   = hi_bit_ff[GW-1:WORD_SHIFT];
   assign lo_pos    = (word_ff == lo_word) ? lo_bit_ff[4:0] : 5'd0;
   assign hi_pos    = (word_ff == hi_word) ? hi_bit_ff[4:0] : 5'd31;
   assign word_mask = ({WORD_BITS{1'b1}} << lo_pos) & ({WORD_BITS{1'b1}} >> (5'd31 - hi_pos));

   // Range checks on the latched item.
   assign cnt_nz    = (count_ff != '0);
   assign cnt_fit   = NW'(count_ff) <= NW'(npg_ff);
   assign free_fit  = (LW'(page_ff) + LW'(count_ff)) <= LW'(npg_ff);
   assign claim_fit = LW'(page_ff) < LW'(npg_ff);
   assign go_scan   = (mode_ff == MODE_ALLOC) && cnt_nz && cnt_fit;
   assign go_mark   = ((mode_ff == MODE_FREE) && cnt_nz && !below_ff && free_fit) ||
                      ((mode_ff == MODE_CLAIM) && !below_ff && claim_fit);

   // Run counter: eight pages of the current slice, first hit wins.
   assign slice_used = ram_rdata[{slice_ff, 3'b000} +: 8] | ~word_mask[{slice_ff, 3'b000} +: 8];

   always_comb begin
      run_v    = run_ff;
      scan_hit = 1'b0;
      hit_k    = 3'd0;
      for (int k = 0; k < 8; k++) begin
         if (!scan_hit) begin
            if (slice_used[k]) begin
               run_v = '0;
            end else begin
               run_v = run_v + NW'(1);
               if (run_v == NW'(count_ff)) begin
                  scan_hit = 1'b1;
                  hit_k    = 3'(k);
               end
            end
         end
      end
   end

   assign hit_bit    = {word_ff, slice_ff, hit_k};
   assign hit_start  = hit_bit - GW'(count_ff) + GW'(1);
   assign start_page = lo_bit_ff - pool_bit;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (word_ff == AW'(WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_LOCATE;
            end
         end
         ST_LOCATE: begin
            state_in = ST_RANGE;
         end
         ST_RANGE: begin
            if (go_scan) begin
               state_in = ST_SCAN_RD;
            end else if (go_mark) begin
               state_in = ST_MARK_RD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_BITS;
         end
         ST_SCAN_BITS: begin
            if (scan_hit) begin
               state_in = ST_MARK_RD;
            end else if (slice_ff == 2'd3) begin
               state_in = (word_ff == hi_word) ? ST_DONE : ST_SCAN_RD;
            end
         end
         ST_MARK_RD: begin
            state_in = ST_MARK_WR;
         end
         ST_MARK_WR: begin
            if (word_ff == hi_word) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_MARK_RD;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Outputs of the sequencer: RAM write and request stall.
   always_comb begin
      ram_we    = 1'b0;
      ram_wdata = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
         end
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_MARK_WR: begin
            ram_we    = 1'b1;
            ram_wdata = set_ff ? (ram_rdata | word_mask) : (ram_rdata & ~word_mask);
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   // Datapath.
   always_comb begin
      mode_in   = mode_ff;
      pool_in   = pool_ff;
      count_in  = count_ff;
      addr_in   = addr_ff;
      base_in   = base_ff;
      npg_in    = npg_ff;
      page_in   = page_ff;
      below_in  = below_ff;
      word_in   = word_ff;
      lo_bit_in = lo_bit_ff;
      hi_bit_in = hi_bit_ff;
      run_in    = run_ff;
      slice_in  = slice_ff;
      set_in    = set_ff;
      ok_in     = ok_ff;
      case (state_ff)
         ST_CLEAR: begin
            word_in = word_ff + AW'(1);
         end
         ST_IDLE: begin
            if (req_xfer) begin
               mode_in  = mode_type'(req_mode);
               pool_in  = req_pool;
               count_in = req_page_count;
               addr_in  = req_address;
               base_in  = req_pool ? ubase_ff : kbase_ff;
               // clamp the pool size to the bitmap capacity
               npg_in   = (NW'(pages_sel) > NW'(MAX_PAGES)) ? PCW'(MAX_PAGES) : PCW'(pages_sel);
            end
         end
         ST_LOCATE: begin
            below_in = addr_ff < base_ff;
            page_in  = PGW'((addr_ff - base_ff) >> PAGE_SHIFT);
         end
         ST_RANGE: begin
            ok_in = 1'b0;
            if (go_scan) begin
               lo_bit_in = pool_bit;
               hi_bit_in = pool_bit + GW'(npg_ff) - GW'(1);
               word_in   = pool_bit[GW-1:WORD_SHIFT];
               run_in    = '0;
               slice_in  = 2'd0;
            end else if (go_mark) begin
               lo_bit_in = pool_bit + GW'(page_ff);
               hi_bit_in = (mode_ff == MODE_FREE) ?
                           pool_bit + GW'(page_ff) + GW'(count_ff) - GW'(1) :
                           pool_bit + GW'(page_ff);
               word_in   = lo_bit_in[GW-1:WORD_SHIFT];
               set_in    = (mode_ff != MODE_FREE);
               ok_in     = 1'b1;
            end
         end
         ST_SCAN_BITS: begin
            run_in = run_v;
            if (scan_hit) begin
               // narrow the range to the run and mark it
               lo_bit_in = hit_start;
               hi_bit_in = hit_bit;
               word_in   = hit_start[GW-1:WORD_SHIFT];
               set_in    = 1'b1;
               ok_in     = 1'b1;
            end else if (slice_ff == 2'd3) begin
               slice_in = 2'd0;
               if (word_ff != hi_word) begin
                  word_in = word_ff + AW'(1);
               end
            end else begin
               slice_in = slice_ff + 2'd1;
            end
         end
         ST_MARK_WR: begin
            if (word_ff != hi_word) begin
               word_in = word_ff + AW'(1);
            end
         end
         default: begin
            ok_in = ok_ff;
         end
      endcase
   end

   // Response register: load from DONE when empty or drained this cycle.
   always_comb begin
      rsp_valid_in        = rsp_valid_ff && rsp_stall;
      rsp_page_address_in = rsp_page_address_ff;
      rsp_ok_in           = rsp_ok_ff;
      if (rsp_load) begin
         rsp_valid_in        = 1'b1;
         rsp_ok_in           = ok_ff;
         rsp_page_address_in = (ok_ff && (mode_ff == MODE_ALLOC)) ?
                               base_ff + (ADDR_W'(start_page) << PAGE_SHIFT) : addr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         word_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         kbase_ff     <= KERNEL_BASE_RST;
         kpages_ff    <= KERNEL_PAGES_RST;
         ubase_ff     <= USER_BASE_RST;
         upages_ff    <= USER_PAGES_RST;
      end else begin
         state_ff     <= state_in;
         word_ff      <= word_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (reg_index_type'(csr_index))
               REG_KERNEL_BASE:  kbase_ff  <= csr_wdata;
               REG_KERNEL_PAGES: kpages_ff <= csr_wdata[CNT_W-1:0];
               REG_USER_BASE:    ubase_ff  <= csr_wdata;
               REG_USER_PAGES:   upages_ff <= csr_wdata[CNT_W-1:0];
               default:          kbase_ff  <= kbase_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      mode_ff             <= mode_in;
      pool_ff             <= pool_in;
      count_ff            <= count_in;
      addr_ff             <= addr_in;
      base_ff             <= base_in;
      npg_ff              <= npg_in;
      page_ff             <= page_in;
      below_ff            <= below_in;
      lo_bit_ff           <= lo_bit_in;
      hi_bit_ff           <= hi_bit_in;
      run_ff              <= run_in;
      slice_ff            <= slice_in;
      set_ff              <= set_in;
      ok_ff               <= ok_in;
      rsp_page_address_ff <= rsp_page_address_in;
      rsp_ok_ff           <= rsp_ok_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_page_address = rsp_page_address_ff;
   assign rsp_ok           = rsp_ok_ff;

`ifndef SYNTHESIS
   // The scan never writes the bitmap.
   a_scan_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN_BITS) |-> !ram_we)
      else $error("bitmap written during scan");

   // A run never outgrows the requested length without a hit.
   a_run_below_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN_BITS) |-> (run_ff < NW'(count_ff)))
      else $error("run counter passed the requested length");

   // A hit goes straight to marking.
   a_hit_marks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN_BITS) && scan_hit |=> (state_ff == ST_MARK_RD) && set_ff)
      else $error("hit not followed by marking");

   // Marking stays inside the range.
   a_mark_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MARK_WR) |-> (word_ff >= lo_word) && (word_ff <= hi_word))
      else $error("mark outside the run");
`endif

endmodule

`default_nettype wire
